@@ sv/ndrcp_pkg.sv @@
// Shared types, codes and helpers of the nearest-depth row and column projection.
`default_nettype none

package ndrcp_pkg;

    localparam int PIXEL_W      = 8;
    localparam int INDEX_W      = 9;
    localparam int KIND_W       = 2;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 10;
    localparam int WIDTH_REG_W  = 10;
    localparam int HEIGHT_REG_W = 9;

    localparam logic [PIXEL_W-1:0] VALUE_NONE = 8'hFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_ROW      = 2'd0,
        KIND_ROW_BAND = 2'd1,
        KIND_COL_BAND = 2'd2
    } t_kind;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_index;

    // A zero reading never lowers a minimum.
    function automatic logic [PIXEL_W-1:0] fold_min(input logic [PIXEL_W-1:0] cur,
                                                    input logic [PIXEL_W-1:0] v);
        return ((v != '0) && (v < cur)) ? v : cur;
    endfunction

endpackage

`default_nettype wire

@@ sv/nearest_depth_row_col_projection.sv @@
// Top level of the nearest-depth row and column projection.
//
// Depth pixels enter in raster order on the valid/ready input channel, one word per
// pixel. Each row's smallest nonzero value leaves on the valid/ready result channel
// at the end of that row; at the end of the frame the row-band minima and then the
// column-band minima follow. The final band word carries o_last, as does the row
// word of every row but the last. The block takes one pixel per cycle unless a
// configuration write or a row end waiting for the output holds it. Column minima
// live in a single-port-write, single-port-read memory of MAX_WIDTH bytes; a pixel
// reads its column on acceptance and writes it back from the write-back stage, with
// forwarding when the next pixel hits the same column. A row result passes from the
// write-back stage to the output register. At frame end the ROW_BANDS plus
// COLUMN_BANDS band words come out one per cycle while the receiver takes them;
// input flows until the next row end needs the output. If the receiver stalls, the
// output register holds its word and the input backs up once a row end reaches the
// write-back stage. A configuration write holds the input while it re-derives the
// band position of the current row and column. Reset clears positions, the running
// row minimum and all band minima; the column memory needs no clearing pass.
`default_nettype none

module nearest_depth_row_col_projection #(
    parameter int MAX_WIDTH    = 640,
    parameter int MAX_HEIGHT   = 480,
    parameter int ROW_BANDS    = 3,
    parameter int COLUMN_BANDS = 5
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [ndrcp_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [ndrcp_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [ndrcp_pkg::PIXEL_W-1:0]          i_pixel,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [ndrcp_pkg::KIND_W-1:0]           o_kind,
    output logic [ndrcp_pkg::INDEX_W-1:0]          o_index,
    output logic [ndrcp_pkg::PIXEL_W-1:0]          o_value,
    output logic                                   o_last
);

    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SWC = WW + 5;
    localparam int SWR = HW + 5;
    localparam int MC  = (2 ** SWC + COLUMN_BANDS - 1) / COLUMN_BANDS;
    localparam int MR  = (2 ** SWR + ROW_BANDS - 1) / ROW_BANDS;
    localparam int PWC = WW + SWC + 1;
    localparam int PWR = HW + SWR + 1;
    localparam int CBW = $clog2(COLUMN_BANDS + 1);
    localparam int RBW = $clog2(ROW_BANDS + 1);
    localparam int CIW = (COLUMN_BANDS > 1) ? $clog2(COLUMN_BANDS) : 1;
    localparam int RIW = (ROW_BANDS > 1) ? $clog2(ROW_BANDS) : 1;
    localparam int NB  = ROW_BANDS + COLUMN_BANDS;
    localparam int EW  = $clog2(NB);
    localparam int PW  = ndrcp_pkg::PIXEL_W;
    localparam int W_RST  = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
    localparam int H_RST  = (MAX_HEIGHT < 480) ? MAX_HEIGHT : 480;
    localparam int BW_RST = W_RST / COLUMN_BANDS;
    localparam int BH_RST = H_RST / ROW_BANDS;

    function automatic logic [WW-1:0] clamp_w(input logic [ndrcp_pkg::WIDTH_REG_W-1:0] v);
        if (v == '0) begin
            return WW'(1);
        end else if (32'(v) > 32'(MAX_WIDTH)) begin
            return WW'(MAX_WIDTH);
        end else begin
            return WW'(v);
        end
    endfunction

    function automatic logic [HW-1:0] clamp_h(input logic [ndrcp_pkg::HEIGHT_REG_W-1:0] v);
        if (v == '0) begin
            return HW'(1);
        end else if (32'(v) > 32'(MAX_HEIGHT)) begin
            return HW'(MAX_HEIGHT);
        end else begin
            return HW'(v);
        end
    endfunction

    // Configuration and geometry.
    logic [WW-1:0]  r_w, r_bw, cfg_w, cfg_bw;
    logic [HW-1:0]  r_h, r_bh, cfg_h, cfg_bh;
    logic [PWC-1:0] cfg_w_prod;
    logic [PWR-1:0] cfg_h_prod;

    // Positions and band trackers.
    logic [CW-1:0]  r_col, r_cb_pos;
    logic [RW-1:0]  r_row, r_rb_pos;
    logic [CBW-1:0] r_cb_idx;
    logic [RBW-1:0] r_rb_idx;
    logic [PW-1:0]  r_row_min, pix_row_min;
    logic           r_fix_busy, fix_c, fix_r;

    // Write-back stage.
    logic           r_s1_valid, r_s1_first, r_s1_last_row, r_s1_row_end;
    logic           r_s1_cb_hit, r_s1_rb_hit;
    logic [CW-1:0]  r_s1_col;
    logic [RW-1:0]  r_s1_row;
    logic [PW-1:0]  r_s1_pix, r_s1_row_min;
    logic [CIW-1:0] r_s1_cb;
    logic [RIW-1:0] r_s1_rb;
    logic           r_fwd;
    logic [PW-1:0]  r_fwd_data, r_mem_q, cm_old, cm_new;
    logic [PW-1:0]  r_mem [MAX_WIDTH];

    // Band minima and the frame-end snapshot.
    logic [PW-1:0]  r_cb_min [COLUMN_BANDS];
    logic [PW-1:0]  r_rb_min [ROW_BANDS];
    logic [PW-1:0]  n_cb_min [COLUMN_BANDS];
    logic [PW-1:0]  n_rb_min [ROW_BANDS];
    logic [PW-1:0]  r_shadow [NB];

    // Output register and band emitter.
    logic                              r_out_valid, r_out_last;
    ndrcp_pkg::t_kind                  r_out_kind, emit_kind;
    logic [ndrcp_pkg::INDEX_W-1:0]     r_out_index, emit_index;
    logic [PW-1:0]                     r_out_value;
    logic                              r_emit_busy, emit_go, emit_last;
    logic [EW-1:0]                     r_emit_cnt;

    logic accept, row_end, last_row, cb_in, rb_in, cb_wrap, rb_wrap;
    logic out_free, s1_go, s1_frame_end;

    assign cfg_w      = clamp_w(i_cfg_data[ndrcp_pkg::WIDTH_REG_W-1:0]);
    assign cfg_h      = clamp_h(i_cfg_data[ndrcp_pkg::HEIGHT_REG_W-1:0]);
    assign cfg_w_prod = PWC'(cfg_w) * PWC'(MC);
    assign cfg_h_prod = PWR'(cfg_h) * PWR'(MR);
    assign cfg_bw     = WW'(cfg_w_prod >> SWC);
    assign cfg_bh     = HW'(cfg_h_prod >> SWR);

    assign out_free     = !r_out_valid || i_ready;
    assign s1_go        = r_s1_valid && (!r_s1_row_end || (out_free && !r_emit_busy));
    assign s1_frame_end = r_s1_row_end && r_s1_last_row;
    assign o_ready      = i_rst_n && !r_fix_busy && !i_cfg_we && (!r_s1_valid || s1_go);
    assign accept       = i_valid && o_ready;

    assign row_end  = ((WW + 1)'(r_col) + (WW + 1)'(1)) >= (WW + 1)'(r_w);
    assign last_row = ((HW + 1)'(r_row) + (HW + 1)'(1)) >= (HW + 1)'(r_h);
    assign pix_row_min = ndrcp_pkg::fold_min(r_row_min, i_pixel);
    assign cb_in   = (r_bw != '0) && (32'(r_cb_idx) < COLUMN_BANDS);
    assign rb_in   = (r_bh != '0) && (32'(r_rb_idx) < ROW_BANDS);
    assign cb_wrap = ((WW + 1)'(r_cb_pos) + (WW + 1)'(1)) == (WW + 1)'(r_bw);
    assign rb_wrap = ((HW + 1)'(r_rb_pos) + (HW + 1)'(1)) == (HW + 1)'(r_bh);
    assign fix_c   = (r_bw != '0) && (WW'(r_cb_pos) >= r_bw)
                     && (32'(r_cb_idx) < COLUMN_BANDS);
    assign fix_r   = (r_bh != '0) && (HW'(r_rb_pos) >= r_bh)
                     && (32'(r_rb_idx) < ROW_BANDS);

    assign cm_old = r_s1_first ? ndrcp_pkg::VALUE_NONE : (r_fwd ? r_fwd_data : r_mem_q);
    assign cm_new = ndrcp_pkg::fold_min(cm_old, r_s1_pix);

    always_comb begin
        n_cb_min = r_cb_min;
        n_rb_min = r_rb_min;
        if (r_s1_cb_hit) begin
            n_cb_min[r_s1_cb] = ndrcp_pkg::fold_min(r_cb_min[r_s1_cb], cm_new);
        end
        if (r_s1_row_end && r_s1_rb_hit) begin
            n_rb_min[r_s1_rb] = ndrcp_pkg::fold_min(r_rb_min[r_s1_rb], r_s1_row_min);
        end
    end

    assign emit_go   = r_emit_busy && out_free;
    assign emit_last = (32'(r_emit_cnt) == NB - 1);

    always_comb begin
        if (32'(r_emit_cnt) < ROW_BANDS) begin
            emit_kind  = ndrcp_pkg::KIND_ROW_BAND;
            emit_index = ndrcp_pkg::INDEX_W'(r_emit_cnt);
        end else begin
            emit_kind  = ndrcp_pkg::KIND_COL_BAND;
            emit_index = ndrcp_pkg::INDEX_W'(r_emit_cnt - EW'(ROW_BANDS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem_q <= r_mem[r_col];
        end
        if (s1_go) begin
            r_mem[r_s1_col] <= cm_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col      <= r_col;
            r_s1_row      <= r_row;
            r_s1_first    <= (r_row == '0);
            r_s1_pix      <= i_pixel;
            r_s1_last_row <= last_row;
            r_s1_row_end  <= row_end;
            r_s1_row_min  <= pix_row_min;
            r_s1_cb_hit   <= last_row && cb_in;
            r_s1_cb       <= CIW'(r_cb_idx);
            r_s1_rb_hit   <= rb_in;
            r_s1_rb       <= RIW'(r_rb_idx);
            r_fwd         <= r_s1_valid && (r_s1_col == r_col);
            r_fwd_data    <= cm_new;
        end
        if (s1_go && r_s1_row_end) begin
            r_out_kind  <= ndrcp_pkg::KIND_ROW;
            r_out_index <= ndrcp_pkg::INDEX_W'(r_s1_row);
            r_out_value <= r_s1_row_min;
            r_out_last  <= !r_s1_last_row;
        end else if (emit_go) begin
            r_out_kind  <= emit_kind;
            r_out_index <= emit_index;
            r_out_value <= r_shadow[r_emit_cnt];
            r_out_last  <= emit_last;
        end
        if (s1_go && s1_frame_end) begin
            for (int i = 0; i < ROW_BANDS; i++) begin
                r_shadow[i] <= n_rb_min[i];
            end
            for (int i = 0; i < COLUMN_BANDS; i++) begin
                r_shadow[ROW_BANDS + i] <= n_cb_min[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w         <= WW'(W_RST);
            r_bw        <= WW'(BW_RST);
            r_h         <= HW'(H_RST);
            r_bh        <= HW'(BH_RST);
            r_col       <= '0;
            r_row       <= '0;
            r_row_min   <= ndrcp_pkg::VALUE_NONE;
            r_cb_pos    <= '0;
            r_cb_idx    <= '0;
            r_rb_pos    <= '0;
            r_rb_idx    <= '0;
            r_fix_busy  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_emit_busy <= 1'b0;
            r_emit_cnt  <= '0;
            for (int i = 0; i < COLUMN_BANDS; i++) begin
                r_cb_min[i] <= ndrcp_pkg::VALUE_NONE;
            end
            for (int i = 0; i < ROW_BANDS; i++) begin
                r_rb_min[i] <= ndrcp_pkg::VALUE_NONE;
            end
        end else begin
            if (i_cfg_we) begin
                case (ndrcp_pkg::t_cfg_index'(i_cfg_index))
                    ndrcp_pkg::CFG_WIDTH: begin
                        r_w  <= cfg_w;
                        r_bw <= cfg_bw;
                    end
                    ndrcp_pkg::CFG_HEIGHT: begin
                        r_h  <= cfg_h;
                        r_bh <= cfg_bh;
                    end
                    default: begin
                    end
                endcase
                // The band of the current row and column is found again by
                // stepping through the bands with the new sizes.
                r_fix_busy <= 1'b1;
                r_cb_pos   <= r_col;
                r_cb_idx   <= '0;
                r_rb_pos   <= r_row;
                r_rb_idx   <= '0;
            end else if (r_fix_busy) begin
                if (fix_c) begin
                    r_cb_pos <= r_cb_pos - CW'(r_bw);
                    r_cb_idx <= r_cb_idx + CBW'(1);
                end
                if (fix_r) begin
                    r_rb_pos <= r_rb_pos - RW'(r_bh);
                    r_rb_idx <= r_rb_idx + RBW'(1);
                end
                r_fix_busy <= fix_c || fix_r;
            end else if (accept) begin
                if (row_end) begin
                    r_col     <= '0;
                    r_row_min <= ndrcp_pkg::VALUE_NONE;
                    r_cb_pos  <= '0;
                    r_cb_idx  <= '0;
                    if (last_row) begin
                        r_row    <= '0;
                        r_rb_pos <= '0;
                        r_rb_idx <= '0;
                    end else begin
                        r_row <= r_row + RW'(1);
                        if (rb_wrap) begin
                            r_rb_pos <= '0;
                            if (32'(r_rb_idx) < ROW_BANDS) begin
                                r_rb_idx <= r_rb_idx + RBW'(1);
                            end
                        end else begin
                            r_rb_pos <= r_rb_pos + RW'(1);
                        end
                    end
                end else begin
                    r_col     <= r_col + CW'(1);
                    r_row_min <= pix_row_min;
                    if (cb_wrap) begin
                        r_cb_pos <= '0;
                        if (32'(r_cb_idx) < COLUMN_BANDS) begin
                            r_cb_idx <= r_cb_idx + CBW'(1);
                        end
                    end else begin
                        r_cb_pos <= r_cb_pos + CW'(1);
                    end
                end
            end

            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_go) begin
                if (s1_frame_end) begin
                    for (int i = 0; i < COLUMN_BANDS; i++) begin
                        r_cb_min[i] <= ndrcp_pkg::VALUE_NONE;
                    end
                    for (int i = 0; i < ROW_BANDS; i++) begin
                        r_rb_min[i] <= ndrcp_pkg::VALUE_NONE;
                    end
                end else begin
                    r_cb_min <= n_cb_min;
                    r_rb_min <= n_rb_min;
                end
            end

            if ((s1_go && r_s1_row_end) || emit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            if (s1_go && s1_frame_end) begin
                r_emit_busy <= 1'b1;
                r_emit_cnt  <= '0;
            end else if (emit_go) begin
                if (emit_last) begin
                    r_emit_busy <= 1'b0;
                end
                r_emit_cnt <= r_emit_cnt + EW'(1);
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_out_kind;
    assign o_index = r_out_index;
    assign o_value = r_out_value;
    assign o_last  = r_out_last;

endmodule

`default_nettype wire

@@ sv/ndrcp_checker.sv @@
// Port-level assertions for the nearest-depth row and column projection, with its bind.
`default_nettype none

module ndrcp_checker #(
    parameter int ROW_BANDS    = 3,
    parameter int COLUMN_BANDS = 5
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic [ndrcp_pkg::KIND_W-1:0]       o_kind,
    input logic [ndrcp_pkg::INDEX_W-1:0]      o_index,
    input logic [ndrcp_pkg::PIXEL_W-1:0]      o_value,
    input logic                               o_last
);

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_index)
                                && $stable(o_value) && $stable(o_last))
        else $error("result word changed while stalled");

    a_value_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_value != '0)
        else $error("a minimum of zero was reported");

    a_bands_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && (o_kind == ndrcp_pkg::KIND_ROW_BAND)
        && (32'(o_index) == ROW_BANDS - 1)
        |=> o_valid && (o_kind == ndrcp_pkg::KIND_COL_BAND) && (o_index == '0))
        else $error("column bands did not follow the last row band");

    a_frame_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == ndrcp_pkg::KIND_COL_BAND)
        |-> o_last == (32'(o_index) == COLUMN_BANDS - 1))
        else $error("last flag misplaced in the column bands");

endmodule

bind nearest_depth_row_col_projection ndrcp_checker #(
    .ROW_BANDS    (ROW_BANDS),
    .COLUMN_BANDS (COLUMN_BANDS)
) u_ndrcp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_kind  (o_kind),
    .o_index (o_index),
    .o_value (o_value),
    .o_last  (o_last)
);

`default_nettype wire
